// ===== src/hkset_pkg.sv =====
package hkset_pkg;

    localparam int KEY_W     = 32;
    localparam int IDX_OUT_W = 10;
    localparam int SHIFT_W   = 5;

    localparam logic [SHIFT_W-1:0] XS_SHIFT_FIRST = SHIFT_W'(17);

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    function automatic logic [KEY_W-1:0] mul_const(input logic [1:0] step);
        logic [KEY_W-1:0] k;
        case (step)
            2'd0:    k = 32'hed5ad4bb;
            2'd1:    k = 32'hac4c1b51;
            2'd2:    k = 32'h31848bab;
            default: k = 32'h00000001;
        endcase
        return k;
    endfunction

    function automatic logic [SHIFT_W-1:0] xs_shift(input logic [1:0] step);
        logic [SHIFT_W-1:0] s;
        case (step)
            2'd0:    s = SHIFT_W'(11);
            2'd1:    s = SHIFT_W'(15);
            2'd2:    s = SHIFT_W'(14);
            default: s = SHIFT_W'(0);
        endcase
        return s;
    endfunction

endpackage

// ===== src/hkset_if.sv =====
interface hkset_req_if import hkset_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;
    logic             insert_if_absent;

    modport source (output valid, output key, output insert_if_absent, input ready);
    modport sink   (input valid, input key, input insert_if_absent, output ready);
endinterface

interface hkset_rsp_if import hkset_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [IDX_OUT_W-1:0] entry_index;

    modport source (output valid, output status, output entry_index, input ready);
    modport sink   (input valid, input status, input entry_index, output ready);
endinterface

// ===== src/hkset_hash.sv =====
module hkset_hash import hkset_pkg::*; #(
    parameter int BUCKETS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [KEY_W-1:0]           i_key,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int BW   = $clog2(BUCKETS);
    localparam bit POW2 = ((1 << BW) == BUCKETS);
    localparam logic [2*KEY_W-1:0] RECIP_WIDE =
        ((2*KEY_W)'(1) << (KEY_W - 1 + BW)) / (2*KEY_W)'(BUCKETS);
    localparam logic [KEY_W-1:0] RECIP = RECIP_WIDE[KEY_W-1:0];

    typedef enum logic [2:0] {
        H_IDLE,
        H_MUL,
        H_XS,
        H_MOD,
        H_FIX
    } t_hstate;

    t_hstate          r_state;
    logic [KEY_W-1:0] r_val;
    logic [1:0]       r_step;
    logic [BW:0]      r_q;
    logic [BW-1:0]    r_bucket;
    logic             r_done;

    logic [KEY_W-1:0]   xs;
    logic [KEY_W-1:0]   mul_op;
    logic [2*KEY_W-1:0] prod;
    logic [BW:0]        q_b;
    logic [BW:0]        rem_est;
    logic [BW:0]        rem_fix;

    assign xs      = r_val ^ (r_val >> xs_shift(r_step));
    assign mul_op  = (r_state == H_MOD) ? RECIP : mul_const(r_step);
    assign prod    = (2*KEY_W)'(r_val) * (2*KEY_W)'(mul_op);
    assign q_b     = r_q * (BW+1)'(BUCKETS);
    assign rem_est = r_val[BW:0] - q_b;
    assign rem_fix = (rem_est >= (BW+1)'(BUCKETS)) ? rem_est - (BW+1)'(BUCKETS) : rem_est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                H_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_val   <= i_key ^ (i_key >> XS_SHIFT_FIRST);
                        r_step  <= 2'd0;
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    r_val   <= prod[KEY_W-1:0];
                    r_state <= H_XS;
                end
                H_XS: begin
                    r_val <= xs;
                    if (r_step == 2'd2) begin
                        if (POW2) begin
                            r_bucket <= xs[BW-1:0];
                            r_done   <= 1'b1;
                            r_state  <= H_IDLE;
                        end else begin
                            r_state <= H_MOD;
                        end
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= H_MUL;
                    end
                end
                H_MOD: begin
                    r_q     <= prod[KEY_W-1+BW +: BW+1];
                    r_state <= H_FIX;
                end
                H_FIX: begin
                    r_bucket <= rem_fix[BW-1:0];
                    r_done   <= 1'b1;
                    r_state  <= H_IDLE;
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_bucket;

endmodule

// ===== src/hashed_key_set_lookup_insert_unit.sv =====
// Channel  | Dir | Payload                      | Transfer
// i_req    | in  | key, insert_if_absent        | valid & ready
// o_rsp    | out | status, entry_index          | valid & ready
//
// The unit takes the item, hashes it (one shared multiplier, three passes),
// fetches the bucket head, reads and compares each chain entry visited, and
// closes a miss; the hash adds a bucket remainder when BUCKETS is not a power of two.
// Reset empties the table at once through per-bucket valid bits.
// i_req is ready only between items; a finished result waits in the output
// register and a new item may be taken meanwhile.
module hashed_key_set_lookup_insert_unit import hkset_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int BUCKETS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hkset_req_if.sink    i_req,
    hkset_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(ENTRIES + 1);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW = $clog2(BUCKETS);
    localparam int XW = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
    localparam logic [IW-1:0] EMPTY = IW'(ENTRIES);

    typedef enum logic [2:0] {
        T_IDLE,
        T_HASH,
        T_HEAD_RD,
        T_HEAD,
        T_ENT_RD,
        T_CMP,
        T_DEC
    } t_state;

    t_state             r_state;
    logic [KEY_W-1:0]   r_key;
    logic               r_ins;
    logic [BW-1:0]      r_bucket;
    logic [IW-1:0]      r_head;
    logic [IW-1:0]      r_cur;
    logic [IW-1:0]      r_steps;
    logic [IW-1:0]      r_used;
    logic [BUCKETS-1:0] r_head_vld;
    logic               r_ovld;
    t_status            r_ostatus;
    logic [IDX_OUT_W-1:0] r_oidx;

    logic [IW-1:0]       r_head_mem [BUCKETS];
    logic [IW-1:0]       r_head_rd;
    logic                r_head_rv;
    logic [IW+KEY_W-1:0] r_ent_mem [ENTRIES];
    logic [IW+KEY_W-1:0] r_ent_rd;

    logic          hash_start;
    logic          hash_done;
    logic [BW-1:0] hash_bucket;
    logic          out_free;
    logic          key_hit;
    logic [IW-1:0] ent_link;
    logic          ins_go;
    logic          rsp_load;
    logic [XW-1:0] cur_x;
    logic [XW-1:0] used_x;

    hkset_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (i_req.key),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    assign i_req.ready = (r_state == T_IDLE);
    assign hash_start  = i_req.valid && i_req.ready;
    assign out_free    = !r_ovld || o_rsp.ready;
    assign key_hit     = (r_ent_rd[KEY_W-1:0] == r_key);
    assign ent_link    = r_ent_rd[KEY_W +: IW];
    assign ins_go      = (r_state == T_DEC) && out_free && r_ins && (r_used != EMPTY);
    assign rsp_load    = out_free && (((r_state == T_CMP) && key_hit) || (r_state == T_DEC));
    assign cur_x       = XW'(r_cur);
    assign used_x      = XW'(r_used);

    always_ff @(posedge i_clk) begin
        if (ins_go) begin
            r_head_mem[r_bucket] <= r_used;
        end
        r_head_rd <= r_head_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (ins_go) begin
            r_ent_mem[r_used[AW-1:0]] <= {r_head, r_key};
        end
        r_ent_rd <= r_ent_mem[r_cur[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_IDLE;
            r_used     <= '0;
            r_head_vld <= '0;
            r_head_rv  <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_head_rv <= r_head_vld[r_bucket];
            if (rsp_load) begin
                r_ovld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (hash_start) begin
                        r_key   <= i_req.key;
                        r_ins   <= i_req.insert_if_absent;
                        r_state <= T_HASH;
                    end
                end
                T_HASH: begin
                    if (hash_done) begin
                        r_bucket <= hash_bucket;
                        r_state  <= T_HEAD_RD;
                    end
                end
                T_HEAD_RD: r_state <= T_HEAD;
                T_HEAD: begin
                    r_head  <= r_head_rv ? r_head_rd : EMPTY;
                    r_cur   <= r_head_rv ? r_head_rd : EMPTY;
                    r_steps <= '0;
                    r_state <= T_ENT_RD;
                end
                T_ENT_RD: begin
                    if (r_cur >= EMPTY || r_steps == EMPTY) begin
                        r_state <= T_DEC;
                    end else begin
                        r_state <= T_CMP;
                    end
                end
                T_CMP: begin
                    if (key_hit) begin
                        if (out_free) begin
                            r_ostatus <= ST_FOUND;
                            r_oidx    <= cur_x[IDX_OUT_W-1:0];
                            r_state   <= T_IDLE;
                        end
                    end else begin
                        r_cur   <= ent_link;
                        r_steps <= r_steps + 1'b1;
                        r_state <= T_ENT_RD;
                    end
                end
                T_DEC: begin
                    if (out_free) begin
                        r_oidx  <= '0;
                        r_state <= T_IDLE;
                        if (!r_ins) begin
                            r_ostatus <= ST_ABSENT;
                        end else if (r_used == EMPTY) begin
                            r_ostatus <= ST_FULL;
                        end else begin
                            r_ostatus            <= ST_INSERTED;
                            r_oidx               <= used_x[IDX_OUT_W-1:0];
                            r_head_vld[r_bucket] <= 1'b1;
                            r_used               <= r_used + 1'b1;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_ovld;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.entry_index = r_oidx;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= EMPTY)
        else $error("entry count beyond capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_go |=> r_used == $past(r_used) + 1'b1)
        else $error("insert did not advance entry count");

    a_hash_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> r_state == T_HASH)
        else $error("hash result outside hash wait");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_ENT_RD || r_state == T_CMP) |-> r_steps <= r_used)
        else $error("chain walk longer than entries in use");

    a_hit_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_CMP && key_hit) |-> r_cur < r_used)
        else $error("hit on an unallocated entry");

endmodule
